[hdl/periodic_density_grid_binning_core_defines.svh]
// assertion macros shared by the checker
`ifndef PERIODIC_DENSITY_GRID_BINNING_CORE_DEFINES_SVH
`define PERIODIC_DENSITY_GRID_BINNING_CORE_DEFINES_SVH

// same-cycle implication
`define PDGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdgb check failed");

// next-cycle implication
`define PDGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdgb check failed");

`endif

[hdl/pdgb_pkg.sv]
package pdgb_pkg;

    // default sizes
    localparam int MAX_COMPONENTS_DEF = 4;
    localparam int GRID_X_DEF         = 16;
    localparam int GRID_Y_DEF         = 16;
    localparam int GRID_Z_DEF         = 16;
    localparam int COUNT_BITS_DEF     = 32;

    // fixed field widths
    localparam int CYCLE_W    = 32;
    localparam int POS_W      = 32;
    localparam int COEF_W     = 21;
    localparam int FRAC_W     = 36;
    localparam int ROW_W      = 63;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BIN_W      = 8;
    localparam int GRID_MAX_W = 9;
    localparam int RES_CNT_W  = 32;

    // command codes
    localparam logic CMD_BIN  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // grid select codes
    localparam logic GRID_BOX   = 1'b0;
    localparam logic GRID_FRAME = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_USE_FW  = 3'd7;

    typedef logic [BIN_W-1:0] bin_t;

    typedef struct packed {
        bin_t x;
        bin_t y;
        bin_t z;
    } bins_t;

    typedef struct packed {
        logic                     cmd;
        logic [CYCLE_W-1:0]       cycle_number;
        logic [1:0]               component;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic                     which_grid;
        logic [3:0]               read_bin_x;
        logic [3:0]               read_bin_y;
        logic [3:0]               read_bin_z;
    } in_item_t;

    typedef struct packed {
        logic                 was_sampled;
        logic [3:0]           box_bin_x;
        logic [3:0]           box_bin_y;
        logic [3:0]           box_bin_z;
        logic [RES_CNT_W-1:0] bin_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_UPDATE
    } state_t;

endpackage

[hdl/pdgb_ram.sv]
module pdgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/pdgb_rem.sv]
module pdgb_rem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic [pdgb_pkg::CYCLE_W-1:0]   dividend,
    input  logic [pdgb_pkg::PERIOD_W-1:0]  divisor,
    output logic                           done,
    output logic                           zero
);

    localparam int CNT_W = $clog2(pdgb_pkg::CYCLE_W);
    localparam int DW    = pdgb_pkg::PERIOD_W;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [pdgb_pkg::CYCLE_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;

    // one restoring step per cycle, msb first
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        shifted   = {rem_reg, quo_reg[pdgb_pkg::CYCLE_W-1]};
        diff      = shifted - {1'b0, d_reg};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            // a zero period behaves as one
            d_next   = (divisor == '0) ? DW'(1) : divisor;
        end
        else if (run_reg)
        begin
            quo_next = quo_reg << 1;
            rem_next = (shifted >= {1'b0, d_reg}) ? diff[DW-1:0] : shifted[DW-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(pdgb_pkg::CYCLE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign zero = (rem_reg == '0);

endmodule

[hdl/pdgb_mac.sv]
module pdgb_mac #(
    parameter int GRID_X = pdgb_pkg::GRID_X_DEF,
    parameter int GRID_Y = pdgb_pkg::GRID_Y_DEF,
    parameter int GRID_Z = pdgb_pkg::GRID_Z_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [5:0][pdgb_pkg::ROW_W-1:0]    mtx,
    input  logic signed [pdgb_pkg::POS_W-1:0]  pos_x,
    input  logic signed [pdgb_pkg::POS_W-1:0]  pos_y,
    input  logic signed [pdgb_pkg::POS_W-1:0]  pos_z,
    output logic                               done,
    output pdgb_pkg::bins_t                    box_bins,
    output pdgb_pkg::bins_t                    frame_bins
);

    localparam int FW   = pdgb_pkg::FRAC_W;
    localparam int CW   = pdgb_pkg::COEF_W;
    localparam int PW   = pdgb_pkg::POS_W;
    localparam int GW   = pdgb_pkg::GRID_MAX_W;
    localparam int PROD_W = CW + PW;

    // issue counters: matrix row 0..5, column 0..2
    logic       run_reg, run_next;
    logic [2:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;

    // multiply stage
    logic signed [CW-1:0]     coef;
    logic signed [PW-1:0]     pos;
    logic signed [PROD_W-1:0] prod;
    logic [FW-1:0]            prod_reg;
    logic                     p_vld_reg, p_first_reg, p_last_reg;
    logic [2:0]               p_row_reg;

    // accumulate stage, only the fraction bits matter
    logic [FW-1:0] acc_reg;
    logic          a_done_reg;
    logic [2:0]    a_row_reg;

    // bin stage
    logic [FW+GW-1:0] scaled_x, scaled_y, scaled_z;
    logic             done_reg;
    pdgb_pkg::bins_t  box_reg, frame_reg;

    always_comb
    begin
        run_next = run_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (go)
        begin
            run_next = 1'b1;
            row_next = '0;
            col_next = '0;
        end
        else if (run_reg)
        begin
            if (col_reg == 2'd2)
            begin
                col_next = '0;
                row_next = row_reg + 3'd1;
                if (row_reg == 3'd5)
                begin
                    run_next = 1'b0;
                end
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        unique case (col_reg)
            2'd0:
            begin
                coef = mtx[row_reg][0 +: CW];
                pos  = pos_x;
            end
            2'd1:
            begin
                coef = mtx[row_reg][CW +: CW];
                pos  = pos_y;
            end
            default:
            begin
                coef = mtx[row_reg][2*CW +: CW];
                pos  = pos_z;
            end
        endcase
        prod = coef * pos;
    end

    always_comb
    begin
        scaled_x = (FW+GW)'(acc_reg) * (FW+GW)'(GRID_X);
        scaled_y = (FW+GW)'(acc_reg) * (FW+GW)'(GRID_Y);
        scaled_z = (FW+GW)'(acc_reg) * (FW+GW)'(GRID_Z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            p_vld_reg  <= 1'b0;
            a_done_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            run_reg    <= run_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            p_vld_reg  <= run_reg;
            a_done_reg <= p_vld_reg && p_last_reg;
            done_reg   <= a_done_reg && (a_row_reg == 3'd5);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod[FW-1:0];
        p_first_reg <= (col_reg == 2'd0);
        p_last_reg  <= (col_reg == 2'd2);
        p_row_reg   <= row_reg;
        if (p_vld_reg)
        begin
            acc_reg   <= (p_first_reg ? '0 : acc_reg) + prod_reg;
            a_row_reg <= p_row_reg;
        end
        if (a_done_reg)
        begin
            unique case (a_row_reg)
                3'd0: box_reg.x   <= pdgb_pkg::bin_t'(scaled_x >> FW);
                3'd1: box_reg.y   <= pdgb_pkg::bin_t'(scaled_y >> FW);
                3'd2: box_reg.z   <= pdgb_pkg::bin_t'(scaled_z >> FW);
                3'd3: frame_reg.x <= pdgb_pkg::bin_t'(scaled_x >> FW);
                3'd4: frame_reg.y <= pdgb_pkg::bin_t'(scaled_y >> FW);
                3'd5: frame_reg.z <= pdgb_pkg::bin_t'(scaled_z >> FW);
                default: ;
            endcase
        end
    end

    assign done       = done_reg;
    assign box_bins   = box_reg;
    assign frame_bins = frame_reg;

endmodule

[hdl/periodic_density_grid_binning_core.sv]
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------
// command   | in        | start high, busy low  | item   (pdgb_pkg::in_item_t)
// result    | out       | done, one cycle       | result (pdgb_pkg::out_item_t)
// config    | in        | cfg_we, no wait       | cfg_index, cfg_data
//
// a bin command runs the 32-step cycle remainder, which sets its length, and
// the 18 shared multiplies of both matrices beside it
// a read command steps through address, memory read and result
// after reset a clearing pass zeroes both histograms, one entry per cycle,
// MAX_COMPONENTS*GRID_X*GRID_Y*GRID_Z entries (16384 at default sizes)
// busy stays high during the pass and while a command is at work
// done marks the result beat for exactly one cycle; the receiver cannot stall
module periodic_density_grid_binning_core #(
    parameter int MAX_COMPONENTS = pdgb_pkg::MAX_COMPONENTS_DEF,
    parameter int GRID_X         = pdgb_pkg::GRID_X_DEF,
    parameter int GRID_Y         = pdgb_pkg::GRID_Y_DEF,
    parameter int GRID_Z         = pdgb_pkg::GRID_Z_DEF,
    parameter int COUNT_BITS     = pdgb_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pdgb_pkg::in_item_t                 item,
    output logic                               done,
    output pdgb_pkg::out_item_t                result,
    input  logic                               cfg_we,
    input  logic [pdgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdgb_pkg::ROW_W-1:0]         cfg_data
);

    // histogram geometry
    localparam int DEPTH = MAX_COMPONENTS * GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int STR_Y = GRID_Z;
    localparam int STR_X = GRID_Y * GRID_Z;
    localparam int STR_C = GRID_X * STR_X;
    // wide enough for any index combination before truncation
    localparam int AC_W  = AW + pdgb_pkg::BIN_W + 2;
    localparam int GW    = pdgb_pkg::GRID_MAX_W;
    localparam logic [6:0] MAXC = 7'(MAX_COMPONENTS);

    // configuration registers
    logic [2:0][pdgb_pkg::ROW_W-1:0]   box_rows_reg;
    logic [2:0][pdgb_pkg::ROW_W-1:0]   frame_rows_reg;
    logic [pdgb_pkg::PERIOD_W-1:0]     period_reg;
    logic                              use_fw_reg;

    // sequencer
    pdgb_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             mac_go;
    logic             clr_on;
    logic             upd_on;
    logic [AW-1:0]    clr_cnt_reg;

    // latched command and unit completion
    pdgb_pkg::in_item_t item_reg;
    logic               mac_fin_reg;
    logic               rem_fin_reg;

    // shared unit outputs
    logic               mac_done;
    pdgb_pkg::bins_t    box_bins;
    pdgb_pkg::bins_t    frame_bins;
    logic               rem_done;
    logic               rem_zero;

    // address and qualify
    logic              is_read;
    logic              comp_ok;
    logic              read_ok;
    pdgb_pkg::bins_t   box_sel;
    pdgb_pkg::bins_t   frame_sel;
    logic [AW-1:0]     box_addr_calc;
    logic [AW-1:0]     frame_addr_calc;
    logic [AW-1:0]     box_addr_reg;
    logic [AW-1:0]     frame_addr_reg;
    logic              box_ok_reg;
    logic              frame_ok_reg;

    // memory ports
    logic                  box_we, frame_we;
    logic [AW-1:0]         box_waddr, frame_waddr;
    logic [COUNT_BITS-1:0] box_wdata, frame_wdata;
    logic [COUNT_BITS-1:0] box_rdata, frame_rdata;
    logic                  box_sat, frame_sat;

    // result
    pdgb_pkg::out_item_t result_reg, result_next;
    logic                done_reg;

    // ---------------------------------------------------------------
    // configuration writes, one register per write beat, no read-back
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_rows_reg   <= '0;
            frame_rows_reg <= '0;
            period_reg     <= pdgb_pkg::PERIOD_W'(1);
            use_fw_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdgb_pkg::REG_BOX_A:   box_rows_reg[0]   <= cfg_data;
                pdgb_pkg::REG_BOX_B:   box_rows_reg[1]   <= cfg_data;
                pdgb_pkg::REG_BOX_C:   box_rows_reg[2]   <= cfg_data;
                pdgb_pkg::REG_FRAME_A: frame_rows_reg[0] <= cfg_data;
                pdgb_pkg::REG_FRAME_B: frame_rows_reg[1] <= cfg_data;
                pdgb_pkg::REG_FRAME_C: frame_rows_reg[2] <= cfg_data;
                pdgb_pkg::REG_PERIOD:  period_reg <= cfg_data[pdgb_pkg::PERIOD_W-1:0];
                pdgb_pkg::REG_USE_FW:  use_fw_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // shared units: the matrix multiply-accumulate and the remainder
    // ---------------------------------------------------------------
    pdgb_mac #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (mac_go),
        .mtx        ({frame_rows_reg, box_rows_reg}),
        .pos_x      (item_reg.pos_x),
        .pos_y      (item_reg.pos_y),
        .pos_z      (item_reg.pos_z),
        .done       (mac_done),
        .box_bins   (box_bins),
        .frame_bins (frame_bins)
    );

    // the remainder unit latches the cycle number straight off the port
    pdgb_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (mac_go),
        .dividend (item.cycle_number),
        .divisor  (period_reg),
        .done     (rem_done),
        .zero     (rem_zero)
    );

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdgb_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = pdgb_pkg::ST_IDLE;
                end
            end
            pdgb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (item.cmd == pdgb_pkg::CMD_READ) ?
                                 pdgb_pkg::ST_ADDR : pdgb_pkg::ST_CALC;
                end
            end
            pdgb_pkg::ST_CALC:
            begin
                if (mac_fin_reg && rem_fin_reg)
                begin
                    state_next = pdgb_pkg::ST_ADDR;
                end
            end
            pdgb_pkg::ST_ADDR:   state_next = pdgb_pkg::ST_READ;
            pdgb_pkg::ST_READ:   state_next = pdgb_pkg::ST_UPDATE;
            pdgb_pkg::ST_UPDATE: state_next = pdgb_pkg::ST_IDLE;
            default:             state_next = pdgb_pkg::ST_CLEAR;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        busy   = (state_reg != pdgb_pkg::ST_IDLE);
        accept = start && (state_reg == pdgb_pkg::ST_IDLE);
        mac_go = accept && (item.cmd == pdgb_pkg::CMD_BIN);
        clr_on = (state_reg == pdgb_pkg::ST_CLEAR);
        upd_on = (state_reg == pdgb_pkg::ST_UPDATE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pdgb_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            mac_fin_reg <= 1'b0;
            rem_fin_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= upd_on;
            if (clr_on)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            // completion flags are sticky until the next command
            if (accept)
            begin
                mac_fin_reg <= 1'b0;
                rem_fin_reg <= 1'b0;
            end
            else
            begin
                if (mac_done)
                begin
                    mac_fin_reg <= 1'b1;
                end
                if (rem_done)
                begin
                    rem_fin_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // bin addresses and qualification
    // ---------------------------------------------------------------
    always_comb
    begin
        is_read = (item_reg.cmd == pdgb_pkg::CMD_READ);
        comp_ok = (7'(item_reg.component) < MAXC);
        read_ok = comp_ok
                  && (GW'(item_reg.read_bin_x) < GW'(GRID_X))
                  && (GW'(item_reg.read_bin_y) < GW'(GRID_Y))
                  && (GW'(item_reg.read_bin_z) < GW'(GRID_Z));
        if (is_read)
        begin
            box_sel.x = pdgb_pkg::bin_t'(item_reg.read_bin_x);
            box_sel.y = pdgb_pkg::bin_t'(item_reg.read_bin_y);
            box_sel.z = pdgb_pkg::bin_t'(item_reg.read_bin_z);
            frame_sel = box_sel;
        end
        else
        begin
            box_sel   = box_bins;
            frame_sel = frame_bins;
        end
        // cell = ((comp*GRID_X + x)*GRID_Y + y)*GRID_Z + z, as constant strides
        box_addr_calc = AW'(AC_W'(item_reg.component) * AC_W'(STR_C)
                          + AC_W'(box_sel.x) * AC_W'(STR_X)
                          + AC_W'(box_sel.y) * AC_W'(STR_Y)
                          + AC_W'(box_sel.z));
        frame_addr_calc = AW'(AC_W'(item_reg.component) * AC_W'(STR_C)
                            + AC_W'(frame_sel.x) * AC_W'(STR_X)
                            + AC_W'(frame_sel.y) * AC_W'(STR_Y)
                            + AC_W'(frame_sel.z));
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == pdgb_pkg::ST_ADDR)
        begin
            box_addr_reg   <= box_addr_calc;
            frame_addr_reg <= frame_addr_calc;
            if (is_read)
            begin
                box_ok_reg   <= read_ok;
                frame_ok_reg <= read_ok;
            end
            else
            begin
                // counted only when the cycle gate is open
                box_ok_reg   <= comp_ok && rem_zero;
                frame_ok_reg <= comp_ok && rem_zero && use_fw_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // histograms: read-modify-write, or zero fill during the clearing pass
    // ---------------------------------------------------------------
    always_comb
    begin
        box_sat     = &box_rdata;
        frame_sat   = &frame_rdata;
        box_we      = clr_on || (upd_on && !is_read && box_ok_reg && !box_sat);
        frame_we    = clr_on || (upd_on && !is_read && frame_ok_reg && !frame_sat);
        box_waddr   = clr_on ? clr_cnt_reg : box_addr_reg;
        frame_waddr = clr_on ? clr_cnt_reg : frame_addr_reg;
        box_wdata   = clr_on ? '0 : box_rdata + COUNT_BITS'(1);
        frame_wdata = clr_on ? '0 : frame_rdata + COUNT_BITS'(1);
    end

    pdgb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (box_waddr),
        .wdata (box_wdata),
        .raddr (box_addr_reg),
        .rdata (box_rdata)
    );

    pdgb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_addr_reg),
        .rdata (frame_rdata)
    );

    // ---------------------------------------------------------------
    // result beat
    // ---------------------------------------------------------------
    always_comb
    begin
        result_next = '0;
        if (is_read)
        begin
            if (box_ok_reg)
            begin
                result_next.bin_count = (item_reg.which_grid == pdgb_pkg::GRID_FRAME) ?
                                        pdgb_pkg::RES_CNT_W'(frame_rdata) :
                                        pdgb_pkg::RES_CNT_W'(box_rdata);
            end
        end
        else
        begin
            result_next.was_sampled = box_ok_reg;
            result_next.box_bin_x   = 4'(box_bins.x);
            result_next.box_bin_y   = 4'(box_bins.y);
            result_next.box_bin_z   = 4'(box_bins.z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_on)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/pdgb_checker.sv]
`include "periodic_density_grid_binning_core_defines.svh"

module pdgb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input pdgb_pkg::out_item_t            result
);

    logic accept;
    logic read_shape;
    logic bin_shape;

    assign accept     = start && !busy;
    assign read_shape = !result.was_sampled && (result.box_bin_x == '0)
                        && (result.box_bin_y == '0) && (result.box_bin_z == '0);
    assign bin_shape  = (result.bin_count == '0);

    // an accepted command makes the block busy in the next cycle
    `PDGB_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)

    // one beat per command, never two in a row
    `PDGB_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)

    // a result always closes a busy stretch
    `PDGB_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy))

    // a beat carries either read fields or bin fields, not both
    `PDGB_ASSERT_IMP(a_done_shape, clk, rst_n, done, read_shape || bin_shape)

endmodule

bind periodic_density_grid_binning_core pdgb_checker u_pdgb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
